/* rtl/hsv_to_rgb_converter_unit_defines.svh */
// assertion macros for the hsv to rgb converter checker
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, masked while in reset
`define HSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define HSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define HSV_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/hsv_pkg.sv */
package hsv_pkg;

  typedef logic [7:0] chan_t;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  localparam logic [8:0] HUE_MAX = 9'd360;
  localparam logic [8:0] HUE_STEP = 9'd60;
  localparam logic [6:0] PCT_MAX = 7'd100;

  // levels are kept as k = percent numerator over 600000, channel = k*255/600000
  // = floor(floor(k*17/64)/625)
  localparam logic [19:0] LOWER_MUL = 20'd60;
  localparam logic [19:0] FULL_MUL = 20'd6000;
  localparam logic [23:0] NUM_MUL = 24'd17;
  localparam int unsigned NUM_SHIFT = 6;

  // ceil(2^28 / 625), exact for quotients of 18-bit dividends
  localparam logic [36:0] RECIP = 37'd429497;
  localparam int unsigned RECIP_SHIFT = 28;

  localparam int unsigned LANES = 4;
  localparam int unsigned L_FULL = 0;
  localparam int unsigned L_RISE = 1;
  localparam int unsigned L_FALL = 2;
  localparam int unsigned L_LOW = 3;

  // k*17/64, the first half of the divide by 600000/255
  function automatic logic [17:0] pre_scale(input logic [19:0] k);
    logic [23:0] num;
    num = 24'(k) * NUM_MUL;
    return num[NUM_SHIFT +: 18];
  endfunction

endpackage

/* rtl/hsv_to_rgb_converter_unit.sv */
// hsv to rgb converter, six register stages
// an accepted word is registered in each of stages 1 to 6; out_valid is v6_r
// throughput: one word per cycle unless stalled; a stage holds only while the next is full
// reset: synchronous active-low rst_n clears all stage valid bits; data regs are not reset
module hsv_to_rgb_converter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [8:0]          in_hue_deg,
  input  logic [6:0]          in_sat_pct,
  input  logic [6:0]          in_val_pct,
  input  logic [7:0]          in_alpha_in,
  output logic                out_valid,
  input  logic                out_stall,
  output hsv_pkg::chan_t      out_red_out,
  output hsv_pkg::chan_t      out_green_out,
  output hsv_pkg::chan_t      out_blue_out,
  output hsv_pkg::chan_t      out_alpha_out
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  // a stage loads when it is empty or the next stage moves
  assign en6 = !v6_r || !out_stall;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: clamp, sector and hue within sector
  logic [8:0]       hue_c;
  logic [6:0]       sat_c, val_c;
  logic [2:0]       sec_raw;
  logic [8:0]       hue_rem;
  logic [5:0]       h1_nxt;
  hsv_pkg::sector_t sector1_nxt;

  logic [5:0]       h1_r;
  hsv_pkg::sector_t sector1_r;
  logic [6:0]       sat1_r, val1_r;
  logic [7:0]       alpha1_r;

  always_comb begin
    hue_c = (in_hue_deg > hsv_pkg::HUE_MAX) ? hsv_pkg::HUE_MAX : in_hue_deg;
    sat_c = (in_sat_pct > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : in_sat_pct;
    val_c = (in_val_pct > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : in_val_pct;
    sec_raw = 3'(hue_c >= 9'(1 * hsv_pkg::HUE_STEP)) + 3'(hue_c >= 9'(2 * hsv_pkg::HUE_STEP))
            + 3'(hue_c >= 9'(3 * hsv_pkg::HUE_STEP)) + 3'(hue_c >= 9'(4 * hsv_pkg::HUE_STEP))
            + 3'(hue_c >= 9'(5 * hsv_pkg::HUE_STEP)) + 3'(hue_c >= hsv_pkg::HUE_MAX);
    hue_rem = hue_c - 9'(9'(sec_raw) * hsv_pkg::HUE_STEP);
    h1_nxt = hue_rem[5:0];
    // full circle keeps the last sector with zero offset
    sector1_nxt = (sec_raw > 3'(hsv_pkg::SEC_5)) ? hsv_pkg::SEC_5 : hsv_pkg::sector_t'(sec_raw);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      h1_r      <= h1_nxt;
      sector1_r <= sector1_nxt;
      sat1_r    <= sat_c;
      val1_r    <= val_c;
      alpha1_r  <= in_alpha_in;
    end
  end

  // stage 2: v*s and (100-s)*v
  logic [13:0]      vs2_r, lowp2_r;
  logic [6:0]       val2_r;
  logic [5:0]       h2_r;
  hsv_pkg::sector_t sector2_r;
  logic [7:0]       alpha2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      vs2_r     <= 14'(val1_r) * 14'(sat1_r);
      lowp2_r   <= 14'(hsv_pkg::PCT_MAX - sat1_r) * 14'(val1_r);
      val2_r    <= val1_r;
      h2_r      <= h1_r;
      sector2_r <= sector1_r;
      alpha2_r  <= alpha1_r;
    end
  end

  // stage 3: ramp term and level numerators
  logic [19:0]      a3_r, lower3_r, full3_r;
  hsv_pkg::sector_t sector3_r;
  logic [7:0]       alpha3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      a3_r      <= 20'(vs2_r) * 20'(h2_r);
      lower3_r  <= 20'(lowp2_r) * hsv_pkg::LOWER_MUL;
      full3_r   <= 20'(val2_r) * hsv_pkg::FULL_MUL;
      sector3_r <= sector2_r;
      alpha3_r  <= alpha2_r;
    end
  end

  // stage 4: rising and falling, then k*17/64 per lane
  logic [19:0] rise_k, fall_k;
  logic [hsv_pkg::LANES-1:0][17:0] m4_nxt;
  logic [hsv_pkg::LANES-1:0][17:0] m4_r;
  hsv_pkg::sector_t sector4_r;
  logic [7:0]       alpha4_r;

  always_comb begin
    rise_k = lower3_r + a3_r;
    fall_k = full3_r - a3_r;
    m4_nxt[hsv_pkg::L_FULL] = hsv_pkg::pre_scale(full3_r);
    m4_nxt[hsv_pkg::L_RISE] = hsv_pkg::pre_scale(rise_k);
    m4_nxt[hsv_pkg::L_FALL] = hsv_pkg::pre_scale(fall_k);
    m4_nxt[hsv_pkg::L_LOW]  = hsv_pkg::pre_scale(lower3_r);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      m4_r      <= m4_nxt;
      sector4_r <= sector3_r;
      alpha4_r  <= alpha3_r;
    end
  end

  // stage 5: reciprocal multiply for the divide by 625
  logic [hsv_pkg::LANES-1:0][36:0] prod5_r;
  hsv_pkg::sector_t sector5_r;
  logic [7:0]       alpha5_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int i = 0; i < hsv_pkg::LANES; i++) begin
        prod5_r[i] <= 37'(m4_r[i]) * hsv_pkg::RECIP;
      end
      sector5_r <= sector4_r;
      alpha5_r  <= alpha4_r;
    end
  end

  // stage 6: quotient and channel order
  hsv_pkg::chan_t q_full, q_rise, q_fall, q_low;
  hsv_pkg::chan_t red_nxt, green_nxt, blue_nxt;
  hsv_pkg::chan_t red_r, green_r, blue_r, alpha_r;

  always_comb begin
    q_full = prod5_r[hsv_pkg::L_FULL][hsv_pkg::RECIP_SHIFT +: 8];
    q_rise = prod5_r[hsv_pkg::L_RISE][hsv_pkg::RECIP_SHIFT +: 8];
    q_fall = prod5_r[hsv_pkg::L_FALL][hsv_pkg::RECIP_SHIFT +: 8];
    q_low  = prod5_r[hsv_pkg::L_LOW][hsv_pkg::RECIP_SHIFT +: 8];
    unique case (sector5_r)
      hsv_pkg::SEC_0: begin
        red_nxt = q_full; green_nxt = q_rise; blue_nxt = q_low;
      end
      hsv_pkg::SEC_1: begin
        red_nxt = q_fall; green_nxt = q_full; blue_nxt = q_low;
      end
      hsv_pkg::SEC_2: begin
        red_nxt = q_low; green_nxt = q_full; blue_nxt = q_rise;
      end
      hsv_pkg::SEC_3: begin
        red_nxt = q_low; green_nxt = q_fall; blue_nxt = q_full;
      end
      hsv_pkg::SEC_4: begin
        red_nxt = q_rise; green_nxt = q_low; blue_nxt = q_full;
      end
      default: begin
        red_nxt = q_full; green_nxt = q_low; blue_nxt = q_fall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha5_r;
    end
  end

  assign out_valid     = v6_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_alpha_out = alpha_r;

endmodule

/* rtl/hsv_to_rgb_converter_unit_checker.sv */
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsv_to_rgb_converter_unit_sva (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input hsv_pkg::chan_t out_red_out,
  input hsv_pkg::chan_t out_green_out,
  input hsv_pkg::chan_t out_blue_out,
  input hsv_pkg::chan_t out_alpha_out
);

  logic        out_held;
  logic [31:0] out_word;

  assign out_held = out_valid && out_stall;
  assign out_word = {out_red_out, out_green_out, out_blue_out, out_alpha_out};

  // a held result word keeps its data
  `HSV_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "held word changed")

  // backpressure only comes from a stalled result
  `HSV_ASSERT_NOW(a_no_stall_free, !out_stall, !in_stall, "input stalled while output free")

  // an empty output means the pipe has room
  `HSV_ASSERT_NOW(a_no_stall_empty, !out_valid, !in_stall, "input stalled with empty output")

  // reset empties the pipe
  `HSV_ASSERT_RST(a_reset_clear, !rst_n, !out_valid, "result valid after reset")

endmodule

bind hsv_to_rgb_converter_unit hsv_to_rgb_converter_unit_sva u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out),
  .out_alpha_out (out_alpha_out)
);

/* tb/hsv_to_rgb_converter_unit_checker.sv */
module hsv_to_rgb_converter_unit_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic [8:0]     in_hue_deg,
  input  logic [6:0]     in_sat_pct,
  input  logic [6:0]     in_val_pct,
  input  logic [7:0]     in_alpha_in,
  input  logic           out_valid,
  input  logic           out_stall,
  input  hsv_pkg::chan_t out_red_out,
  input  hsv_pkg::chan_t out_green_out,
  input  hsv_pkg::chan_t out_blue_out,
  input  hsv_pkg::chan_t out_alpha_out,
  output int unsigned    failures,
  output int unsigned    in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // levels are numerators over LEVEL_SPAN percent units
  localparam longint unsigned LEVEL_SPAN = 600000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    hsv_pkg::chan_t red;
    hsv_pkg::chan_t green;
    hsv_pkg::chan_t blue;
    hsv_pkg::chan_t alpha;
  } rgba_t;

  rgba_t rgba_due[$];
  rgba_t got_rgba;
  rgba_t want_rgba;

  function automatic hsv_pkg::chan_t level_to_byte(input longint unsigned num);
    return hsv_pkg::chan_t'((num * 255) / (longint'(hsv_pkg::PCT_MAX) * LEVEL_SPAN));
  endfunction

  function automatic rgba_t rgba_of_hsv(input logic [8:0] hue, input logic [6:0] sat,
                                        input logic [6:0] val, input logic [7:0] alpha);
    longint unsigned lh;
    longint unsigned ls;
    longint unsigned lv;
    longint unsigned step;
    longint unsigned dim;
    logic [8:0] hc;
    hsv_pkg::sector_t sec;
    hsv_pkg::chan_t full_c;
    hsv_pkg::chan_t rise_c;
    hsv_pkg::chan_t fall_c;
    hsv_pkg::chan_t low_c;
    rgba_t c;
    hc = (hue > hsv_pkg::HUE_MAX) ? hsv_pkg::HUE_MAX : hue;
    ls = (sat > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : sat;
    lv = (val > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : val;
    lh = hc % hsv_pkg::HUE_STEP;
    // hue 360 would be sector 6, folded onto the last one
    sec = (hc / hsv_pkg::HUE_STEP > 9'(hsv_pkg::SEC_5)) ? hsv_pkg::SEC_5
        : hsv_pkg::sector_t'(3'(hc / hsv_pkg::HUE_STEP));
    step = lv * ls * lh * 100;
    dim = (hsv_pkg::PCT_MAX - ls) * lv * 6000;
    full_c = level_to_byte(lv * LEVEL_SPAN);
    rise_c = level_to_byte(dim + step);
    fall_c = level_to_byte(lv * LEVEL_SPAN - step);
    low_c = level_to_byte(dim);
    case (sec)
      hsv_pkg::SEC_0: c = '{full_c, rise_c, low_c, alpha};
      hsv_pkg::SEC_1: c = '{fall_c, full_c, low_c, alpha};
      hsv_pkg::SEC_2: c = '{low_c, full_c, rise_c, alpha};
      hsv_pkg::SEC_3: c = '{low_c, fall_c, full_c, alpha};
      hsv_pkg::SEC_4: c = '{rise_c, low_c, full_c, alpha};
      default: c = '{full_c, low_c, fall_c, alpha};
    endcase
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rgba_due.push_back(rgba_of_hsv(in_hue_deg, in_sat_pct, in_val_pct, in_alpha_in));
      end
      if (out_valid && !out_stall) begin
        got_rgba = '{out_red_out, out_green_out, out_blue_out, out_alpha_out};
        if (rgba_due.size() == 0) begin
          if (failures < REPORT_MAX)
            $display("%0t: unexpected word r=%0d g=%0d b=%0d a=%0d", $realtime,
                     got_rgba.red, got_rgba.green, got_rgba.blue, got_rgba.alpha);
          failures <= failures + 1;
        end else begin
          want_rgba = rgba_due.pop_front();
          if (got_rgba !== want_rgba) begin
            if (failures < REPORT_MAX)
              $display("%0t: expected rgba %0d %0d %0d %0d got %0d %0d %0d %0d",
                       $realtime, want_rgba.red, want_rgba.green, want_rgba.blue,
                       want_rgba.alpha, got_rgba.red, got_rgba.green, got_rgba.blue,
                       got_rgba.alpha);
            failures <= failures + 1;
          end
        end
      end
    end
    in_flight <= rgba_due.size();
  end

endmodule

/* tb/hsv_to_rgb_converter_unit_test.sv */
module hsv_to_rgb_converter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned HOLD_AFTER = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [8:0] in_hue_deg = '0;
  logic [6:0] in_sat_pct = '0;
  logic [6:0] in_val_pct = '0;
  logic [7:0] in_alpha_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hsv_pkg::chan_t out_red_out;
  hsv_pkg::chan_t out_green_out;
  hsv_pkg::chan_t out_blue_out;
  hsv_pkg::chan_t out_alpha_out;

  int unsigned failures;
  int unsigned in_flight;
  int unsigned words_sent = 0;
  int unsigned quiet = 0;
  bit held_off = 1'b0;

  always #6 clk = ~clk;

  hsv_to_rgb_converter_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue_deg   (in_hue_deg),
    .in_sat_pct   (in_sat_pct),
    .in_val_pct   (in_val_pct),
    .in_alpha_in  (in_alpha_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_alpha_out(out_alpha_out)
  );

  hsv_to_rgb_converter_unit_checker rgba_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue_deg   (in_hue_deg),
    .in_sat_pct   (in_sat_pct),
    .in_val_pct   (in_val_pct),
    .in_alpha_in  (in_alpha_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_alpha_out(out_alpha_out),
    .failures     (failures),
    .in_flight    (in_flight)
  );

  // valid stays high on return so a burst runs back to back
  task automatic send_color(input logic [8:0] hue, input logic [6:0] sat,
                            input logic [6:0] val, input logic [7:0] alpha);
    in_hue_deg <= hue;
    in_sat_pct <= sat;
    in_val_pct <= val;
    in_alpha_in <= alpha;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // mostly in range, with clamped values and the ends of the range mixed in
  function automatic logic [6:0] pick_pct();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'($urandom_range(101, 127));
    if (r == 1) return ($urandom_range(0, 1) != 0) ? hsv_pkg::PCT_MAX : 7'd0;
    return 7'($urandom_range(0, 100));
  endfunction

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned r;
    logic [8:0] hue;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_color(9'd0, 7'd0, 7'd0, 8'h00);
    send_color(9'd0, 7'd100, 7'd100, 8'hFF);
    send_color(9'd60, 7'd100, 7'd100, 8'h55);
    send_color(9'd120, 7'd100, 7'd100, 8'hAA);
    send_color(9'd180, 7'd100, 7'd100, 8'h01);
    send_color(9'd240, 7'd100, 7'd100, 8'h80);
    send_color(9'd300, 7'd100, 7'd100, 8'h7F);
    send_color(9'd359, 7'd100, 7'd100, 8'hFE);
    send_color(9'd360, 7'd100, 7'd100, 8'h10);
    send_color(9'd360, 7'd0, 7'd100, 8'h20);
    send_color(9'd361, 7'd50, 7'd80, 8'h40);
    send_color(9'd511, 7'd127, 7'd127, 8'hFF);
    send_color(9'd59, 7'd100, 7'd100, 8'h02);
    send_color(9'd30, 7'd50, 7'd100, 8'h04);
    send_color(9'd90, 7'd37, 7'd63, 8'h08);
    send_color(9'd150, 7'd1, 7'd99, 8'hC3);
    send_color(9'd210, 7'd99, 7'd1, 8'h3C);
    send_color(9'd270, 7'd73, 7'd45, 8'h5A);
    send_color(9'd330, 7'd100, 7'd50, 8'hA5);
    send_color(9'd45, 7'd127, 7'd100, 8'hF0);
    send_color(9'd100, 7'd0, 7'd127, 8'h0F);
    send_color(9'd256, 7'd64, 7'd64, 8'h99);
    send_color(9'd200, 7'd100, 7'd0, 8'h66);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      r = $urandom_range(0, 9);
      if (r == 0) hue = 9'($urandom_range(361, 511));
      else if (r == 1)
        hue = 9'($urandom_range(0, 6) * 60 + (($urandom_range(0, 1) != 0) ? 59 : 0));
      else hue = 9'($urandom_range(0, 360));
      if (hue > 9'd511) hue = hsv_pkg::HUE_MAX;
      send_color(hue, pick_pct(), pick_pct(), 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (in_flight != 0);
    repeat (10) @(posedge clk);
    if (failures == 0 && in_flight == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random stall stretches, plus one long hold-off to back up the pipe
  initial begin
    int unsigned mode;
    int unsigned len;
    bit s;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && words_sent >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(10, 60);
        for (int k = 0; k < len; k++) begin
          case (mode)
            0: s = 1'b0;
            1: s = ($urandom_range(0, 1) != 0);
            2: s = ($urandom_range(0, 3) != 0);
            default: s = ($urandom_range(0, 7) == 0);
          endcase
          out_stall <= s;
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

/* files.f */
+incdir+rtl
rtl/hsv_pkg.sv
rtl/hsv_to_rgb_converter_unit.sv
rtl/hsv_to_rgb_converter_unit_checker.sv
tb/hsv_to_rgb_converter_unit_checker.sv
tb/hsv_to_rgb_converter_unit_test.sv
